>>> hw/rtl/scpwm_pkg.sv
// ----------------------------------------------------------------------------
// scpwm_pkg
// shared types, register map and reset values of the sixteen-channel pwm
// controller
// ----------------------------------------------------------------------------
package scpwm_pkg;

    localparam int CHANNELS_DEF     = 16;
    localparam int COUNTER_BITS_DEF = 12;
    localparam int TIME_BITS        = 12;

    typedef enum logic [2:0] {
        MODE_SET_PTR = 3'd0,
        MODE_WRITE   = 3'd1,
        MODE_READ    = 3'd2,
        MODE_TICK    = 3'd3,
        MODE_RESET   = 3'd4
    } mode_t;

    localparam logic [7:0] REG_MODE1    = 8'h00;
    localparam logic [7:0] REG_MODE2    = 8'h01;
    localparam logic [7:0] REG_LED_BASE = 8'h06;
    localparam logic [7:0] REG_ALL_BASE = 8'd250;
    localparam logic [7:0] REG_PRESCALE = 8'd254;

    localparam logic [7:0] MODE1_RESET    = 8'h11;
    localparam logic [7:0] MODE2_RESET    = 8'h04;
    localparam logic [7:0] PRESCALE_RESET = 8'h1E;
    localparam logic [7:0] PRESCALE_MIN   = 8'd3;

    localparam int SLEEP_BIT = 4;
    localparam int AI_BIT    = 5;
    localparam int INVRT_BIT = 4;

    typedef struct packed {
        logic                 full;
        logic [TIME_BITS-1:0] count;
    } timing_t;

endpackage

>>> hw/rtl/scpwm_channel_cmp.sv
// ----------------------------------------------------------------------------
// scpwm_channel_cmp
// per-channel on/off window compare against the pwm counter, with full-on,
// full-off and output inversion
// ----------------------------------------------------------------------------
module scpwm_channel_cmp #(
    parameter int CHANNELS     = scpwm_pkg::CHANNELS_DEF,
    parameter int COUNTER_BITS = scpwm_pkg::COUNTER_BITS_DEF
) (
    input  scpwm_pkg::timing_t      on_times  [CHANNELS],
    input  scpwm_pkg::timing_t      off_times [CHANNELS],
    input  logic [COUNTER_BITS-1:0] pwm_count,
    input  logic                    invert,
    output logic [CHANNELS-1:0]     levels
);

    localparam int CMP_W = (COUNTER_BITS > scpwm_pkg::TIME_BITS) ?
                           COUNTER_BITS : scpwm_pkg::TIME_BITS;

    logic [CMP_W-1:0] cnt;

    assign cnt = CMP_W'(pwm_count);

    always_comb
    begin
        logic [CMP_W-1:0] on_c;
        logic [CMP_W-1:0] off_c;
        logic             lvl;
        for (int i = 0; i < CHANNELS; i++)
        begin
            on_c  = CMP_W'(on_times[i].count);
            off_c = CMP_W'(off_times[i].count);
            if (off_times[i].full)
                lvl = 1'b0;
            else if (on_times[i].full)
                lvl = 1'b1;
            else if (on_c < off_c)
                lvl = (cnt >= on_c) && (cnt < off_c);
            else if (on_c > off_c)
                lvl = (cnt >= on_c) || (cnt < off_c);
            else
                lvl = 1'b0;
            levels[i] = lvl ^ invert;
        end
    end

endmodule

>>> hw/rtl/sixteen_channel_pwm_controller.sv
// ----------------------------------------------------------------------------
// sixteen_channel_pwm_controller
// register-level pwm led controller: pointer, register writes and reads,
// oscillator ticks and software reset, one bus event per input word
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one event per word: tdata[2:0] event code (0 set pointer,
//   1 write, 2 read, 3 oscillator tick, 4 software reset), tdata[10:3] byte.
//   m_axis returns exactly one word per input word: read byte, the level of
//   every channel after the event, and the sleep flag.
//   m_axis_tvalid rises in the cycle after acceptance; one word can be accepted
//   every cycle while m_axis_tready is high, since the register update and the
//   channel compare all settle between the input handshake and the output register.
//   s_axis_tready stays high while the output register is empty or being
//   drained; when the receiver stalls, the pending result holds and input is
//   taken again as soon as m_axis_tready returns.
//   rst_n clears every control register to its power-on value (asleep, all
//   channels full off, prescale 30) and empties the output register; the
//   software reset event does the same to the registers without dropping results.
//   prescale writes only take effect while asleep; ticks are ignored then.
// ----------------------------------------------------------------------------
module sixteen_channel_pwm_controller #(
    parameter int CHANNELS     = scpwm_pkg::CHANNELS_DEF,
    parameter int COUNTER_BITS = scpwm_pkg::COUNTER_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // mode[2:0], bus_byte[10:3], zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // read_data[7:0], channel_outputs[23:8],
                                        // sleeping[24], zero
);

    localparam int          LED_END_I = 6 + 4 * CHANNELS;
    localparam logic [7:0]  LED_END   = 8'(LED_END_I);

    logic [7:0]              mode1_reg, mode1_next;
    logic [7:0]              mode2_reg, mode2_next;
    logic [7:0]              aux_reg [4];
    logic [7:0]              aux_next [4];
    logic [7:0]              ptr_reg, ptr_next;
    scpwm_pkg::timing_t      on_reg  [CHANNELS];
    scpwm_pkg::timing_t      on_next [CHANNELS];
    scpwm_pkg::timing_t      off_reg [CHANNELS];
    scpwm_pkg::timing_t      off_next [CHANNELS];
    logic [7:0]              prescale_reg, prescale_next;
    logic [7:0]              pcount_reg, pcount_next;
    logic [COUNTER_BITS-1:0] pwm_reg, pwm_next;

    logic                    out_valid_reg;
    logic [7:0]              rdata_reg, rdata_next;
    logic [15:0]             chan_reg;
    logic                    sleep_reg;

    logic [2:0]              in_mode;
    logic [7:0]              in_byte;
    logic                    accept;
    logic [CHANNELS-1:0]     levels;
    logic [7:0]              led_off;
    logic [5:0]              ch_sel;
    logic [1:0]              sub_sel;
    logic [1:0]              aux_idx;
    logic [1:0]              all_sub;

    assign in_mode       = s_axis_tdata[2:0];
    assign in_byte       = s_axis_tdata[10:3];
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign led_off       = ptr_reg - scpwm_pkg::REG_LED_BASE;
    assign ch_sel        = led_off[7:2];
    assign sub_sel       = led_off[1:0];
    assign aux_idx       = 2'(ptr_reg - 8'd2);
    assign all_sub       = 2'(ptr_reg - scpwm_pkg::REG_ALL_BASE);

    function automatic scpwm_pkg::timing_t write_slot(scpwm_pkg::timing_t t,
                                                      logic hi, logic [7:0] v);
        scpwm_pkg::timing_t r;
        r = t;
        if (hi)
        begin
            r.full         = v[4];
            r.count[11:8]  = v[3:0];
        end
        else
        begin
            r.count[7:0]   = v;
        end
        return r;
    endfunction

    function automatic logic [7:0] read_slot(scpwm_pkg::timing_t t, logic hi);
        return hi ? {3'b000, t.full, t.count[11:8]} : t.count[7:0];
    endfunction

    always_comb
    begin
        mode1_next    = mode1_reg;
        mode2_next    = mode2_reg;
        aux_next      = aux_reg;
        ptr_next      = ptr_reg;
        on_next       = on_reg;
        off_next      = off_reg;
        prescale_next = prescale_reg;
        pcount_next   = pcount_reg;
        pwm_next      = pwm_reg;
        rdata_next    = 8'h00;

        case (in_mode)
            scpwm_pkg::MODE_SET_PTR:
            begin
                ptr_next = in_byte;
            end
            scpwm_pkg::MODE_WRITE:
            begin
                if (ptr_reg == scpwm_pkg::REG_MODE1)
                    mode1_next = in_byte & 8'h7F;
                else if (ptr_reg == scpwm_pkg::REG_MODE2)
                    mode2_next = in_byte & 8'h1F;
                else if (ptr_reg < scpwm_pkg::REG_LED_BASE)
                    aux_next[aux_idx] = in_byte;
                else if (ptr_reg < LED_END)
                begin
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        if (ch_sel == 6'(i))
                        begin
                            if (sub_sel[1])
                                off_next[i] = write_slot(off_reg[i], sub_sel[0], in_byte);
                            else
                                on_next[i] = write_slot(on_reg[i], sub_sel[0], in_byte);
                        end
                    end
                end
                else if (ptr_reg >= scpwm_pkg::REG_ALL_BASE &&
                         ptr_reg < scpwm_pkg::REG_PRESCALE)
                begin
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        if (all_sub[1])
                            off_next[i] = write_slot(off_reg[i], all_sub[0], in_byte);
                        else
                            on_next[i] = write_slot(on_reg[i], all_sub[0], in_byte);
                    end
                end
                else if (ptr_reg == scpwm_pkg::REG_PRESCALE)
                begin
                    if (mode1_reg[scpwm_pkg::SLEEP_BIT])
                        prescale_next = (in_byte < scpwm_pkg::PRESCALE_MIN) ?
                                        scpwm_pkg::PRESCALE_MIN : in_byte;
                end
                if (mode1_next[scpwm_pkg::AI_BIT])
                    ptr_next = ptr_reg + 8'd1;
            end
            scpwm_pkg::MODE_READ:
            begin
                if (ptr_reg == scpwm_pkg::REG_MODE1)
                    rdata_next = mode1_reg;
                else if (ptr_reg == scpwm_pkg::REG_MODE2)
                    rdata_next = mode2_reg;
                else if (ptr_reg < scpwm_pkg::REG_LED_BASE)
                    rdata_next = aux_reg[aux_idx];
                else if (ptr_reg < LED_END)
                begin
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        if (ch_sel == 6'(i))
                            rdata_next = sub_sel[1] ? read_slot(off_reg[i], sub_sel[0])
                                                    : read_slot(on_reg[i], sub_sel[0]);
                    end
                end
                else if (ptr_reg == scpwm_pkg::REG_PRESCALE)
                    rdata_next = prescale_reg;
                if (mode1_reg[scpwm_pkg::AI_BIT])
                    ptr_next = ptr_reg + 8'd1;
            end
            scpwm_pkg::MODE_TICK:
            begin
                if (!mode1_reg[scpwm_pkg::SLEEP_BIT])
                begin
                    if (pcount_reg >= prescale_reg)
                    begin
                        pcount_next = 8'h00;
                        pwm_next    = pwm_reg + COUNTER_BITS'(1);
                    end
                    else
                    begin
                        pcount_next = pcount_reg + 8'd1;
                    end
                end
            end
            scpwm_pkg::MODE_RESET:
            begin
                mode1_next    = scpwm_pkg::MODE1_RESET;
                mode2_next    = scpwm_pkg::MODE2_RESET;
                ptr_next      = 8'h00;
                prescale_next = scpwm_pkg::PRESCALE_RESET;
                pcount_next   = 8'h00;
                pwm_next      = '0;
                for (int i = 0; i < 4; i++)
                    aux_next[i] = 8'h00;
                for (int i = 0; i < CHANNELS; i++)
                begin
                    on_next[i]  = '0;
                    off_next[i] = '{full: 1'b1, count: '0};
                end
            end
            default:
            begin
            end
        endcase
    end

    scpwm_channel_cmp #(
        .CHANNELS     (CHANNELS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_cmp (
        .on_times  (on_next),
        .off_times (off_next),
        .pwm_count (pwm_next),
        .invert    (mode2_next[scpwm_pkg::INVRT_BIT]),
        .levels    (levels)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode1_reg    <= scpwm_pkg::MODE1_RESET;
            mode2_reg    <= scpwm_pkg::MODE2_RESET;
            ptr_reg      <= 8'h00;
            prescale_reg <= scpwm_pkg::PRESCALE_RESET;
            pcount_reg   <= 8'h00;
            pwm_reg      <= '0;
            for (int i = 0; i < 4; i++)
                aux_reg[i] <= 8'h00;
            for (int i = 0; i < CHANNELS; i++)
            begin
                on_reg[i]  <= '0;
                off_reg[i] <= '{full: 1'b1, count: '0};
            end
        end
        else if (accept)
        begin
            mode1_reg    <= mode1_next;
            mode2_reg    <= mode2_next;
            ptr_reg      <= ptr_next;
            prescale_reg <= prescale_next;
            pcount_reg   <= pcount_next;
            pwm_reg      <= pwm_next;
            aux_reg      <= aux_next;
            on_reg       <= on_next;
            off_reg      <= off_next;
        end
    end

    // result word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rdata_reg <= rdata_next;
            chan_reg  <= 16'(levels);
            sleep_reg <= mode1_next[scpwm_pkg::SLEEP_BIT];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, sleep_reg, chan_reg, rdata_reg};

`ifndef SYNTHESIS
    a_accept_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_axis_tvalid)
        else $error("accepted word produced no result");

    a_soft_reset_mode1: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_mode == scpwm_pkg::MODE_RESET) |=>
        (mode1_reg == scpwm_pkg::MODE1_RESET && pwm_reg == '0))
        else $error("software reset did not restore registers");

    a_sleep_freezes_pwm: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_mode == scpwm_pkg::MODE_TICK && mode1_reg[scpwm_pkg::SLEEP_BIT])
        |=> ($stable(pwm_reg) && $stable(pcount_reg)))
        else $error("counter moved while asleep");

    a_prescale_min: assert property (@(posedge clk) disable iff (!rst_n)
        prescale_reg >= scpwm_pkg::PRESCALE_MIN)
        else $error("prescale below minimum");

    a_sleep_flag: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (sleep_reg == mode1_reg[scpwm_pkg::SLEEP_BIT]))
        else $error("sleep flag does not follow mode1");
`endif

endmodule
